// ===== rtl/p12u_pkg.sv =====
// Package for the packed 12-bit sample unpacker: widths, constants and phase codes.
package p12u_pkg;

   // Stream and sample widths
   localparam int WORD_W   = 32;
   localparam int RAW_W    = 12;
   localparam int GAIN_W   = 24;
   localparam int SCALED_W = 20;
   localparam int COUNT_W  = 32;
   localparam int ENERGY_W = 64;
   localparam int CARRY_W  = 8;

   // Gain fraction bits (Q8.16)
   localparam int GAIN_FRAC_BITS = 16;

   // Product of a signed sample and an unsigned gain (gain gets a zero sign bit)
   localparam int PROD_W = RAW_W + GAIN_W + 1;
   localparam int SQ_W   = 2 * RAW_W;

   // Reset value of the gain register
   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

   // Raw codes that flag overload
   localparam logic [RAW_W-1:0] RAW_FULL_SCALE = {RAW_W{1'b1}};
   localparam logic [RAW_W-1:0] RAW_ZERO       = '0;
   localparam logic [RAW_W-1:0] RAW_ONE        = RAW_W'(1);

   // Limits of the scaled result, at product width
   localparam logic signed [PROD_W-1:0] SCALED_MAX = PROD_W'(524287);
   localparam logic signed [PROD_W-1:0] SCALED_MIN = -PROD_W'(524288);

   // Position of a word within its three-word group
   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;

   // Samples held per word
   localparam logic [1:0] SAMPLES_TWO   = 2'd2;
   localparam logic [1:0] SAMPLES_THREE = 2'd3;

endpackage

// ===== rtl/packed_12bit_sample_unpacker.sv =====
// Packed 12-bit sample unpacker: splits packed words into samples, scales and tallies them.
// A word is registered into the sample buffer, each sample then into the result register.
// Throughput: one sample per cycle while not stalled, from one result register; a word
// gives 2 or 3 samples and the next is taken in the cycle its predecessor's last issues.
// Reset (synchronous, active high) clears phase, carry, tally, energy and all valid
// state, and sets the gain to 1.0 (65536).
module packed_12bit_sample_unpacker
   import p12u_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // Configuration
   input  logic                       csr_wr_en,
   input  logic [GAIN_W-1:0]          csr_wr_data,
   // Input beats
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [WORD_W-1:0]          req_packed_word,
   input  logic                       req_new_block,
   // Result beats
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [RAW_W-1:0]    rsp_sample,
   output logic signed [SCALED_W-1:0] rsp_scaled_sample,
   output logic                       rsp_overload,
   output logic [COUNT_W-1:0]         rsp_overload_count,
   output logic [ENERGY_W-1:0]        rsp_energy_total,
   output logic                       rsp_last
);

   // Gain register
   logic [GAIN_W-1:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else if (csr_wr_en) begin
         gain_ff <= csr_wr_data;
      end
   end

   // Group tracking state
   logic [1:0]         phase_ff, phase_in;
   logic [CARRY_W-1:0] carry_ff, carry_in;

   // Sample buffer: raw codes waiting to issue, oldest in slot 0
   logic [RAW_W-1:0] raw0_ff, raw1_ff, raw2_ff;
   logic [RAW_W-1:0] raw0_in, raw1_in, raw2_in;
   logic [1:0]       rem_ff, rem_in;
   logic             clr_ff, clr_in;

   // Running totals
   logic [COUNT_W-1:0]  tally_ff, tally_in;
   logic [ENERGY_W-1:0] energy_ff, energy_in;

   // Result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [RAW_W-1:0]    sample_ff, sample_in;
   logic signed [SCALED_W-1:0] scaled_ff, scaled_in;
   logic                       ovl_ff, ovl_in;
   logic                       last_ff, last_in;

   // Handshake
   logic busy, issue, accept;

   assign busy      = (rem_ff != 2'd0);
   assign issue     = busy && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = busy && !(issue && (rem_ff == 2'd1));
   assign accept    = req_valid && !req_stall;

   // Unpack the incoming word against the current phase
   logic [1:0]         phase_eff;
   logic [CARRY_W-1:0] carry_eff;
   logic [RAW_W-1:0]   unp0, unp1, unp2;
   logic [1:0]         unp_n;
   logic [1:0]         unp_phase;
   logic [CARRY_W-1:0] unp_carry;

   always_comb begin
      phase_eff = req_new_block ? PHASE_FIRST : phase_ff;
      carry_eff = req_new_block ? '0 : carry_ff;
      unp0      = req_packed_word[31:20];
      unp1      = req_packed_word[19:8];
      unp2      = '0;
      unp_n     = SAMPLES_TWO;
      unp_phase = PHASE_SECOND;
      unp_carry = req_packed_word[7:0];
      case (phase_eff)
         PHASE_SECOND: begin
            unp0      = {carry_eff, req_packed_word[31:28]};
            unp1      = req_packed_word[27:16];
            unp2      = req_packed_word[15:4];
            unp_n     = SAMPLES_THREE;
            unp_phase = PHASE_THIRD;
            unp_carry = {4'b0, req_packed_word[3:0]};
         end
         PHASE_THIRD: begin
            unp0      = {carry_eff[3:0], req_packed_word[31:24]};
            unp1      = req_packed_word[23:12];
            unp2      = req_packed_word[11:0];
            unp_n     = SAMPLES_THREE;
            unp_phase = PHASE_FIRST;
            unp_carry = '0;
         end
         // first word of a group; an out-of-range phase behaves the same
         default: begin
            unp0      = req_packed_word[31:20];
            unp1      = req_packed_word[19:8];
            unp2      = '0;
            unp_n     = SAMPLES_TWO;
            unp_phase = PHASE_SECOND;
            unp_carry = req_packed_word[7:0];
         end
      endcase
   end

   // Buffer and phase next state
   always_comb begin
      phase_in = phase_ff;
      carry_in = carry_ff;
      raw0_in  = raw0_ff;
      raw1_in  = raw1_ff;
      raw2_in  = raw2_ff;
      rem_in   = rem_ff;
      clr_in   = clr_ff;
      if (accept) begin
         phase_in = unp_phase;
         carry_in = unp_carry;
         raw0_in  = unp0;
         raw1_in  = unp1;
         raw2_in  = unp2;
         rem_in   = unp_n;
         clr_in   = req_new_block;
      end else if (issue) begin
         raw0_in = raw1_ff;
         raw1_in = raw2_ff;
         rem_in  = rem_ff - 2'd1;
         clr_in  = 1'b0;
      end
   end

   // Per-sample arithmetic on the head of the buffer
   logic signed [RAW_W-1:0]  x;
   logic signed [PROD_W-1:0] prod, shifted;
   logic [SQ_W-1:0]          sq;
   logic [COUNT_W-1:0]       tally_base;

   always_comb begin
      x       = $signed({~raw0_ff[RAW_W-1], raw0_ff[RAW_W-2:0]});
      ovl_in  = (raw0_ff == RAW_FULL_SCALE) || (raw0_ff == RAW_ZERO) || (raw0_ff == RAW_ONE);
      prod    = PROD_W'(x) * $signed({1'b0, gain_ff});
      shifted = prod >>> GAIN_FRAC_BITS;
      if (shifted > SCALED_MAX) begin
         scaled_in = SCALED_MAX[SCALED_W-1:0];
      end else if (shifted < SCALED_MIN) begin
         scaled_in = SCALED_MIN[SCALED_W-1:0];
      end else begin
         scaled_in = shifted[SCALED_W-1:0];
      end
      sq        = $unsigned(SQ_W'(x) * SQ_W'(x));
      sample_in = x;
      last_in   = (rem_ff == 2'd1);

      // new block restarts the tally on its first sample; tally saturates
      tally_base = clr_ff ? '0 : tally_ff;
      if (ovl_in && (tally_base != {COUNT_W{1'b1}})) begin
         tally_in = tally_base + COUNT_W'(1);
      end else begin
         tally_in = tally_base;
      end
      energy_in = energy_ff + ENERGY_W'(sq);
   end

   // Result valid
   always_comb begin
      if (issue) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_FIRST;
         carry_ff     <= '0;
         rem_ff       <= '0;
         clr_ff       <= 1'b0;
         tally_ff     <= '0;
         energy_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         carry_ff     <= carry_in;
         rem_ff       <= rem_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (issue) begin
            tally_ff  <= tally_in;
            energy_ff <= energy_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      raw0_ff <= raw0_in;
      raw1_ff <= raw1_in;
      raw2_ff <= raw2_in;
      if (issue) begin
         sample_ff <= sample_in;
         scaled_ff <= scaled_in;
         ovl_ff    <= ovl_in;
         last_ff   <= last_in;
      end
   end

   // Result beat
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample         = sample_ff;
   assign rsp_scaled_sample  = scaled_ff;
   assign rsp_overload       = ovl_ff;
   assign rsp_overload_count = tally_ff;
   assign rsp_energy_total   = energy_ff;
   assign rsp_last           = last_ff;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the packed 12-bit sample unpacker.
module tb;
   import p12u_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LIMIT_CYCLES = 400000;
   localparam longint SCALED_TOP = 524287;
   localparam longint SCALED_BOTTOM = -524288;
   localparam int unsigned MAX_PRINTED = 40;

   // One unpacked sample as the block should present it
   typedef struct packed {
      logic signed [RAW_W-1:0]    sample;
      logic signed [SCALED_W-1:0] scaled;
      logic                       overload;
      logic [COUNT_W-1:0]         count;
      logic [ENERGY_W-1:0]        energy;
      logic                       last;
   } sample_beat_type;

   // One packed word waiting to be sent
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              new_block;
      logic              hold_for_drain;
   } word_beat_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_wr_en = 1'b0;
   logic [GAIN_W-1:0]          csr_wr_data = '0;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [WORD_W-1:0]          req_packed_word = '0;
   logic                       req_new_block = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [RAW_W-1:0]    rsp_sample;
   logic signed [SCALED_W-1:0] rsp_scaled_sample;
   logic                       rsp_overload;
   logic [COUNT_W-1:0]         rsp_overload_count;
   logic [ENERGY_W-1:0]        rsp_energy_total;
   logic                       rsp_last;

   word_beat_type   word_queue[$];
   sample_beat_type pending_samples[$];
   int unsigned     error_count = 0;
   logic            results_drained = 1'b1;

   // Predictor state, mirrors the block
   logic [1:0]          grp_phase = PHASE_FIRST;
   logic [CARRY_W-1:0]  carried = '0;
   logic [COUNT_W-1:0]  ovl_tally = '0;
   logic [ENERGY_W-1:0] sq_sum = '0;
   logic [GAIN_W-1:0]   gain_setting = GAIN_RESET;

   int unsigned send_gap = 0;
   int unsigned send_calm = 0;
   int unsigned stall_left = 0;
   int unsigned stall_calm = 0;

   packed_12bit_sample_unpacker i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_packed_word    (req_packed_word),
      .req_new_block      (req_new_block),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample         (rsp_sample),
      .rsp_scaled_sample  (rsp_scaled_sample),
      .rsp_overload       (rsp_overload),
      .rsp_overload_count (rsp_overload_count),
      .rsp_energy_total   (rsp_energy_total),
      .rsp_last           (rsp_last)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      if (error_count < MAX_PRINTED)
         $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Expected beat for one raw code
   task automatic predict_sample(input logic [RAW_W-1:0] raw, input logic is_last);
      sample_beat_type b;
      int              x;
      longint          scaled;
      x = int'(raw) - 2048;
      b.overload = (x == 2047) || (x <= -2047);
      if (b.overload && ovl_tally != '1)
         ovl_tally++;
      sq_sum += 64'(longint'(x) * longint'(x));
      scaled = (longint'(x) * longint'(gain_setting)) >>> GAIN_FRAC_BITS;
      if (scaled > SCALED_TOP) scaled = SCALED_TOP;
      if (scaled < SCALED_BOTTOM) scaled = SCALED_BOTTOM;
      b.sample = x[RAW_W-1:0];
      b.scaled = scaled[SCALED_W-1:0];
      b.count = ovl_tally;
      b.energy = sq_sum;
      b.last = is_last;
      pending_samples.push_back(b);
   endtask

   // Split one accepted word into its samples
   task automatic unpack_word(input logic [WORD_W-1:0] w, input logic nb);
      if (nb) begin
         grp_phase = PHASE_FIRST;
         carried = '0;
         ovl_tally = '0;
      end
      case (grp_phase)
         PHASE_SECOND: begin
            predict_sample({carried, w[31:28]}, 1'b0);
            predict_sample(w[27:16], 1'b0);
            predict_sample(w[15:4], 1'b1);
            carried = {4'b0, w[3:0]};
            grp_phase = PHASE_THIRD;
         end
         PHASE_THIRD: begin
            predict_sample({carried[3:0], w[31:24]}, 1'b0);
            predict_sample(w[23:12], 1'b0);
            predict_sample(w[11:0], 1'b1);
            carried = '0;
            grp_phase = PHASE_FIRST;
         end
         default: begin
            predict_sample(w[31:20], 1'b0);
            predict_sample(w[19:8], 1'b1);
            carried = w[7:0];
            grp_phase = PHASE_SECOND;
         end
      endcase
   endtask

   // Word driver
   always @(posedge clock) begin
      word_beat_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap != 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (word_queue.size() != 0 &&
                      !(word_queue[0].hold_for_drain && !results_drained)) begin
            item = word_queue.pop_front();
            req_packed_word <= item.word;
            req_new_block <= item.new_block;
            req_valid <= 1'b1;
            if (send_calm != 0) begin
               send_calm--;
            end else begin
               send_gap = pick_gap();
               if ($urandom_range(0, 24) == 0) send_calm = $urandom_range(20, 80);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (stall_calm != 0) begin
         stall_calm--;
         rsp_stall <= 1'b0;
      end else begin
         stall_left = pick_gap();
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
         else if ($urandom_range(0, 19) == 0) stall_calm = $urandom_range(30, 120);
      end
   end

   // Monitor: check result beats, predict from accepted words
   always @(posedge clock) begin
      sample_beat_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_samples.size() == 0) begin
               flag_mismatch("unexpected result beat", 64'(rsp_sample), 64'd0);
            end else begin
               want = pending_samples.pop_front();
               if (rsp_sample !== want.sample)
                  flag_mismatch("sample", 64'(rsp_sample), 64'(want.sample));
               if (rsp_scaled_sample !== want.scaled)
                  flag_mismatch("scaled_sample", 64'(rsp_scaled_sample), 64'(want.scaled));
               if (rsp_overload !== want.overload)
                  flag_mismatch("overload", 64'(rsp_overload), 64'(want.overload));
               if (rsp_overload_count !== want.count)
                  flag_mismatch("overload_count", 64'(rsp_overload_count), 64'(want.count));
               if (rsp_energy_total !== want.energy)
                  flag_mismatch("energy_total", rsp_energy_total, want.energy);
               if (rsp_last !== want.last)
                  flag_mismatch("last", 64'(rsp_last), 64'(want.last));
            end
         end
         if (req_valid && !req_stall)
            unpack_word(req_packed_word, req_new_block);
      end
   end

   // Drain status, sampled away from the active edge
   always @(negedge clock) begin
      results_drained <= (pending_samples.size() == 0) && !req_valid;
   end

   task automatic push_word(input logic [WORD_W-1:0] w, input logic nb,
                            input logic hold = 1'b0);
      word_beat_type item;
      item.word = w;
      item.new_block = nb;
      item.hold_for_drain = hold;
      word_queue.push_back(item);
   endtask

   // Eight 12-bit codes, first code in the top bits, as three words
   task automatic push_group(input logic [95:0] codes, input logic nb,
                             input logic hold = 1'b0);
      push_word(codes[95:64], nb, hold);
      push_word(codes[63:32], 1'b0);
      push_word(codes[31:0], 1'b0);
   endtask

   // Raw code biased towards the overload edges and mid-scale
   function automatic logic [RAW_W-1:0] pick_code();
      case ($urandom_range(0, 15))
         0: return 12'd0;
         1: return 12'd1;
         2: return 12'd2;
         3: return 12'd4095;
         4: return 12'd4094;
         5: return 12'd2048;
         default: return RAW_W'($urandom);
      endcase
   endfunction

   // Mostly whole blocks of groups, with broken blocks and stray words
   task automatic make_traffic(input int unsigned n_words);
      int unsigned  made;
      int unsigned  r;
      int unsigned  n;
      logic [95:0]  codes;
      made = 0;
      while (made < n_words) begin
         r = $urandom_range(0, 99);
         if (r < 78) begin
            n = $urandom_range(1, 4);
            for (int g = 0; g < n; g++) begin
               if ($urandom_range(0, 3) == 0)
                  codes = {$urandom, $urandom, $urandom};
               else
                  for (int k = 0; k < 8; k++) codes[95 - 12*k -: 12] = pick_code();
               push_group(codes, g == 0, g == 0 && $urandom_range(0, 39) == 0);
            end
            made += 3 * n;
         end else if (r < 90) begin
            n = $urandom_range(1, 5);
            for (int k = 0; k < n; k++) push_word($urandom, k == 0);
            made += n;
         end else begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) push_word($urandom, 1'($urandom_range(0, 1)));
            made += n;
         end
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (word_queue.size() != 0 || req_valid || pending_samples.size() != 0);
   endtask

   task automatic set_gain(input logic [GAIN_W-1:0] g);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= g;
      gain_setting = g;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Watchdog
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Stimulus sequence
   initial begin
      logic [GAIN_W-1:0] g;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: overload edges, mid-scale, all-zero and all-one groups
      push_group({12'd4095, 12'd0, 12'd1, 12'd2, 12'd4094, 12'd2048, 12'd2047, 12'hAAA},
                 1'b1);
      push_group(96'h0, 1'b0);
      push_group({96{1'b1}}, 1'b0);
      // Block restart part-way through a group drops the carried bits
      push_word(32'h8007_FF80, 1'b1);
      push_word(32'h1234_5678, 1'b0);
      push_group({12'd1, 12'd4095, 12'd0, 12'd2048, 12'd3, 12'd4093, 12'd2047, 12'd1},
                 1'b1, 1'b1);
      push_group({48{2'b01}}, 1'b0);
      push_group({48{2'b10}}, 1'b0);
      wait_idle();

      // Random traffic across a range of gains, extremes included
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: g = '0;
            1: g = '1;
            2: g = GAIN_W'(1);
            3: g = GAIN_W'($urandom);
            4: g = GAIN_RESET;
            default: g = GAIN_W'($urandom_range(1 << 16, (1 << 20) - 1));
         endcase
         set_gain(g);
         make_traffic(78);
         wait_idle();
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      if (pending_samples.size() != 0)
         flag_mismatch("samples never delivered", 64'(pending_samples.size()), 64'd0);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/p12u_pkg.sv
rtl/packed_12bit_sample_unpacker.sv
test/tb.sv
